// ===== rtl/core/lr4_audio_crossover_macros.svh =====
// ----------------------------------------------------------------------------
// LR4 crossover assertion macros
// Shared concurrent assertion forms for the crossover RTL.
// ----------------------------------------------------------------------------
`ifndef LR4_AUDIO_CROSSOVER_MACROS_SVH
`define LR4_AUDIO_CROSSOVER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define LR4X_ASSERT_IMP(name, clk, rst_n, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("lr4x assertion failed");

// Next-cycle implication, checked out of reset.
`define LR4X_ASSERT_NXT(name, clk, rst_n, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("lr4x assertion failed");

`endif

// ===== rtl/core/lr4x_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LR4 crossover package
// Widths, fixed-point constants, shared types and saturation helpers.
// ----------------------------------------------------------------------------
package lr4x_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_BITS      = 32;
    localparam int COEF_FRAC_BITS = 30;
    localparam int STATE_BITS     = 48;
    localparam int STATE_FRAC     = 16;
    localparam int STATE_SHIFT    = COEF_FRAC_BITS - STATE_FRAC;
    localparam int ACC_BITS       = 64;

    // Digit-serial multiplier geometry
    localparam int DIGIT_BITS = 8;
    localparam int NUM_DIGITS = (SAMPLE_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int OPND_BITS  = NUM_DIGITS * DIGIT_BITS;
    localparam int CNT_BITS   = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam int PROD_BITS  = COEF_BITS + DIGIT_BITS + 1;

    localparam logic signed [ACC_BITS-1:0] ONE_ACC    = ACC_BITS'(1);
    localparam logic signed [ACC_BITS-1:0] SAMPLE_MAX = (ONE_ACC <<< (SAMPLE_BITS - 1)) - ONE_ACC;
    localparam logic signed [ACC_BITS-1:0] SAMPLE_MIN = -SAMPLE_MAX - ONE_ACC;
    localparam logic signed [ACC_BITS-1:0] STATE_MAX  = (ONE_ACC <<< (STATE_BITS - 1)) - ONE_ACC;
    localparam logic signed [ACC_BITS-1:0] STATE_MIN  = -STATE_MAX - ONE_ACC;
    localparam logic signed [ACC_BITS-1:0] RND_Y      = ONE_ACC <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_BITS-1:0] RND_ST     = ONE_ACC <<< (STATE_SHIFT - 1);

    // Register indexes of the write channel
    typedef enum logic [2:0] {
        CFG_ENABLE,
        CFG_LOW_GAIN,
        CFG_HIGH_GAIN,
        CFG_FB_ONE,
        CFG_FB_TWO
    } t_cfg_index;

    typedef enum logic [2:0] {
        SEC_IDLE,
        SEC_MUL_P,
        SEC_CALC_Y,
        SEC_MUL_F,
        SEC_UPDATE,
        SEC_DONE
    } t_sec_state;

    typedef enum logic [1:0] {
        TOP_IDLE,
        TOP_FILTER,
        TOP_BYPASS
    } t_top_state;

    typedef struct packed {
        logic start;
        logic ack;
    } t_sec_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_sec_stat;

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [ACC_BITS-1:0] v
    );
        logic signed [SAMPLE_BITS-1:0] r;
        if (v > SAMPLE_MAX) begin
            r = SAMPLE_MAX[SAMPLE_BITS-1:0];
        end else if (v < SAMPLE_MIN) begin
            r = SAMPLE_MIN[SAMPLE_BITS-1:0];
        end else begin
            r = v[SAMPLE_BITS-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [STATE_BITS-1:0] sat_state(
        input logic signed [ACC_BITS-1:0] v
    );
        logic signed [STATE_BITS-1:0] r;
        if (v > STATE_MAX) begin
            r = STATE_MAX[STATE_BITS-1:0];
        end else if (v < STATE_MIN) begin
            r = STATE_MIN[STATE_BITS-1:0];
        end else begin
            r = v[STATE_BITS-1:0];
        end
        return r;
    endfunction

    // Bring a delay entry up to coefficient scale
    function automatic logic signed [ACC_BITS-1:0] scale_state(
        input logic signed [STATE_BITS-1:0] d
    );
        logic signed [ACC_BITS-1:0] w;
        w = ACC_BITS'(d);
        return w <<< STATE_SHIFT;
    endfunction

endpackage

// ===== rtl/core/lr4x_section.sv =====
`timescale 1ns / 1ps
`include "lr4_audio_crossover_macros.svh"
// ----------------------------------------------------------------------------
// LR4 crossover band path
// Two cascaded biquad sections run in turn on a digit-serial multiplier.
// ----------------------------------------------------------------------------
module lr4x_section
    import lr4x_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_sec_ctrl                     i_ctrl,
    input  logic                          i_high_pass,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic signed [COEF_BITS-1:0]   i_gain,
    input  logic signed [COEF_BITS-1:0]   i_fb1,
    input  logic signed [COEF_BITS-1:0]   i_fb2,
    output t_sec_stat                     o_stat,
    output logic signed [SAMPLE_BITS-1:0] o_band
);

    t_sec_state r_state, n_state;
    logic                         r_sect, n_sect;
    logic [CNT_BITS-1:0]          r_cnt, n_cnt;
    logic [OPND_BITS-1:0]         r_opnd, n_opnd;
    logic signed [ACC_BITS-1:0]   r_acc0, n_acc0;
    logic signed [ACC_BITS-1:0]   r_acc1, n_acc1;
    logic signed [ACC_BITS-1:0]   r_qs, n_qs;
    logic signed [ACC_BITS-1:0]   r_pr, n_pr;
    logic signed [SAMPLE_BITS-1:0] r_y, n_y;
    logic signed [STATE_BITS-1:0] r_d0a, n_d0a, r_d1a, n_d1a;
    logic signed [STATE_BITS-1:0] r_d0b, n_d0b, r_d1b, n_d1b;

    logic signed [COEF_BITS-1:0]   coef0;
    logic signed [DIGIT_BITS:0]    dig;
    logic signed [PROD_BITS-1:0]   prod0, prod1;
    logic signed [ACC_BITS-1:0]    acc0_step, acc1_step;
    logic                          last_dig;
    logic signed [STATE_BITS-1:0]  d0_sel, d1_sel;
    logic signed [ACC_BITS-1:0]    sum_y, p2, q, qs_new, pr_new, n0, n1;
    logic signed [SAMPLE_BITS-1:0] y_new;
    logic signed [STATE_BITS-1:0]  d0_new, d1_new;

    // Digit-serial multiply: top digit signed, the rest unsigned, MSB first
    assign coef0     = (r_state == SEC_MUL_F) ? i_fb1 : i_gain;
    assign dig       = {(r_cnt == '0) & r_opnd[OPND_BITS-1], r_opnd[OPND_BITS-1 -: DIGIT_BITS]};
    assign prod0     = coef0 * dig;
    assign prod1     = i_fb2 * dig;
    assign acc0_step = (r_acc0 <<< DIGIT_BITS) + ACC_BITS'(prod0);
    assign acc1_step = (r_acc1 <<< DIGIT_BITS) + ACC_BITS'(prod1);
    assign last_dig  = (r_cnt == CNT_BITS'(NUM_DIGITS - 1));

    assign d0_sel = r_sect ? r_d0b : r_d0a;
    assign d1_sel = r_sect ? r_d1b : r_d1a;

    // Section output and the pre-summed feedforward terms
    assign sum_y  = r_acc0 + scale_state(d0_sel) + RND_Y;
    assign y_new  = sat_sample(sum_y >>> COEF_FRAC_BITS);
    assign p2     = r_acc0 <<< 1;
    assign q      = i_high_pass ? -p2 : p2;
    assign qs_new = q + scale_state(d1_sel) + RND_ST;
    assign pr_new = r_acc0 + RND_ST;

    // Delay update after the feedback products
    assign n0     = r_qs - r_acc0;
    assign n1     = r_pr - r_acc1;
    assign d0_new = sat_state(n0 >>> STATE_SHIFT);
    assign d1_new = sat_state(n1 >>> STATE_SHIFT);

    always_comb begin
        n_state = r_state;
        n_sect  = r_sect;
        n_cnt   = r_cnt;
        n_opnd  = r_opnd;
        n_acc0  = r_acc0;
        n_acc1  = r_acc1;
        n_qs    = r_qs;
        n_pr    = r_pr;
        n_y     = r_y;
        n_d0a   = r_d0a;
        n_d1a   = r_d1a;
        n_d0b   = r_d0b;
        n_d1b   = r_d1b;
        case (r_state)
            SEC_IDLE: begin
                if (i_ctrl.start) begin
                    n_state = SEC_MUL_P;
                    n_sect  = 1'b0;
                    n_cnt   = '0;
                    n_opnd  = OPND_BITS'(i_sample);
                    n_acc0  = '0;
                end
            end
            SEC_MUL_P: begin
                n_acc0 = acc0_step;
                n_opnd = r_opnd << DIGIT_BITS;
                if (last_dig) begin
                    n_cnt   = '0;
                    n_state = SEC_CALC_Y;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            SEC_CALC_Y: begin
                n_y     = y_new;
                n_qs    = qs_new;
                n_pr    = pr_new;
                n_opnd  = OPND_BITS'(y_new);
                n_acc0  = '0;
                n_acc1  = '0;
                n_state = SEC_MUL_F;
            end
            SEC_MUL_F: begin
                n_acc0 = acc0_step;
                n_acc1 = acc1_step;
                n_opnd = r_opnd << DIGIT_BITS;
                if (last_dig) begin
                    n_cnt   = '0;
                    n_state = SEC_UPDATE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            SEC_UPDATE: begin
                if (!r_sect) begin
                    // Feed the first section's output into the second
                    n_d0a   = d0_new;
                    n_d1a   = d1_new;
                    n_sect  = 1'b1;
                    n_opnd  = OPND_BITS'(r_y);
                    n_acc0  = '0;
                    n_state = SEC_MUL_P;
                end else begin
                    n_d0b   = d0_new;
                    n_d1b   = d1_new;
                    n_state = SEC_DONE;
                end
            end
            SEC_DONE: begin
                if (i_ctrl.ack) begin
                    n_state = SEC_IDLE;
                end
            end
            default: begin
                n_state = SEC_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEC_IDLE;
            r_sect  <= 1'b0;
            r_cnt   <= '0;
            r_d0a   <= '0;
            r_d1a   <= '0;
            r_d0b   <= '0;
            r_d1b   <= '0;
        end else begin
            r_state <= n_state;
            r_sect  <= n_sect;
            r_cnt   <= n_cnt;
            r_d0a   <= n_d0a;
            r_d1a   <= n_d1a;
            r_d0b   <= n_d0b;
            r_d1b   <= n_d1b;
        end
    end

    always_ff @(posedge i_clk) begin
        r_opnd <= n_opnd;
        r_acc0 <= n_acc0;
        r_acc1 <= n_acc1;
        r_qs   <= n_qs;
        r_pr   <= n_pr;
        r_y    <= n_y;
    end

    assign o_stat.busy = (r_state != SEC_IDLE);
    assign o_stat.done = (r_state == SEC_DONE);
    assign o_band      = r_y;

    `LR4X_ASSERT_IMP(a_start_when_idle, i_clk, i_rst_n, i_ctrl.start, r_state == SEC_IDLE)
    `LR4X_ASSERT_IMP(a_done_after_second, i_clk, i_rst_n, r_state == SEC_DONE, r_sect)
    `LR4X_ASSERT_IMP(a_busy_from_start, i_clk, i_rst_n, $rose(o_stat.busy), $past(i_ctrl.start))

endmodule

// ===== rtl/core/lr4_audio_crossover.sv =====
`timescale 1ns / 1ps
`include "lr4_audio_crossover_macros.svh"
// ----------------------------------------------------------------------------
// LR4 audio crossover
// Fourth-order Linkwitz-Riley split of one audio stream into two bands.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one signed sample word on i_in_sample, taken at an edge
//   where i_in_valid is high and o_in_stall is low. Output channel: a word
//   of o_low_band and o_high_band, taken where o_out_valid is high and
//   i_out_stall is low. Config channel: i_cfg_index selects enable, low
//   gain, high gain, feedback one, feedback two; o_cfg_ready is always high.
//   Timing: the block takes no new input word while one is at work, and
//   takes the next one only once the last result word is loaded into the
//   output register. Each band runs its two biquad sections in turn on an
//   8-bit digit-serial multiplier: the feedforward product, rounding, both
//   feedback products, then the delay update. When disabled the input word
//   is copied to both bands without filtering.
//   Reset clears the registers, the filter delays and both channels.
//   A stalled result word holds in the output register; the block still takes
//   and filters the next input word, then holds it until the output frees up.
// ----------------------------------------------------------------------------
module lr4_audio_crossover
    import lr4x_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input sample channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_in_sample,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0] o_low_band,
    output logic signed [SAMPLE_BITS-1:0] o_high_band,
    // register write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [2:0]                    i_cfg_index,
    input  logic [COEF_BITS-1:0]          i_cfg_data
);

    logic                        r_enable;
    logic signed [COEF_BITS-1:0] r_gain_lo, r_gain_hi, r_fb1, r_fb2;

    t_top_state r_state, n_state;
    logic signed [SAMPLE_BITS-1:0] r_x, n_x;
    logic                          r_out_valid, n_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_low, n_out_low;
    logic signed [SAMPLE_BITS-1:0] r_out_high, n_out_high;

    t_sec_ctrl sec_ctrl;
    t_sec_stat lo_stat, hi_stat;
    logic signed [SAMPLE_BITS-1:0] lo_band, hi_band;
    logic in_accept;
    logic out_free;

    // Register writes: always ready, ignore unknown indexes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= 1'b0;
            r_gain_lo <= '0;
            r_gain_hi <= '0;
            r_fb1     <= '0;
            r_fb2     <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ENABLE:    r_enable  <= i_cfg_data[0];
                CFG_LOW_GAIN:  r_gain_lo <= i_cfg_data;
                CFG_HIGH_GAIN: r_gain_hi <= i_cfg_data;
                CFG_FB_ONE:    r_fb1     <= i_cfg_data;
                CFG_FB_TWO:    r_fb2     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Both band paths run in lockstep off the same start and ack
    lr4x_section u_low (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (sec_ctrl),
        .i_high_pass (1'b0),
        .i_sample    (i_in_sample),
        .i_gain      (r_gain_lo),
        .i_fb1       (r_fb1),
        .i_fb2       (r_fb2),
        .o_stat      (lo_stat),
        .o_band      (lo_band)
    );

    lr4x_section u_high (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (sec_ctrl),
        .i_high_pass (1'b1),
        .i_sample    (i_in_sample),
        .i_gain      (r_gain_hi),
        .i_fb1       (r_fb1),
        .i_fb2       (r_fb2),
        .o_stat      (hi_stat),
        .o_band      (hi_band)
    );

    // Take a new word only while no word is at work
    assign o_in_stall = (r_state != TOP_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    // Output register can load when empty or being drained this cycle
    assign out_free   = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state        = r_state;
        n_x            = r_x;
        n_out_low      = r_out_low;
        n_out_high     = r_out_high;
        n_out_valid    = r_out_valid && i_out_stall;
        sec_ctrl.start = 1'b0;
        sec_ctrl.ack   = 1'b0;
        case (r_state)
            TOP_IDLE: begin
                if (in_accept) begin
                    n_x = i_in_sample;
                    if (r_enable) begin
                        sec_ctrl.start = 1'b1;
                        n_state        = TOP_FILTER;
                    end else begin
                        n_state = TOP_BYPASS;
                    end
                end
            end
            TOP_FILTER: begin
                // Hold the band results in the paths until the output frees up
                if (lo_stat.done && out_free) begin
                    sec_ctrl.ack = 1'b1;
                    n_out_low    = lo_band;
                    n_out_high   = hi_band;
                    n_out_valid  = 1'b1;
                    n_state      = TOP_IDLE;
                end
            end
            TOP_BYPASS: begin
                // Disabled: copy the sample to both bands, leave delays frozen
                if (out_free) begin
                    n_out_low   = r_x;
                    n_out_high  = r_x;
                    n_out_valid = 1'b1;
                    n_state     = TOP_IDLE;
                end
            end
            default: begin
                n_state = TOP_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= TOP_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_out_low  <= n_out_low;
        r_out_high <= n_out_high;
    end

    assign o_out_valid = r_out_valid;
    assign o_low_band  = r_out_low;
    assign o_high_band = r_out_high;

    `LR4X_ASSERT_IMP(a_paths_lockstep, i_clk, i_rst_n,
        lo_stat.done || hi_stat.done, lo_stat.done && hi_stat.done)
    `LR4X_ASSERT_NXT(a_stall_after_accept, i_clk, i_rst_n, in_accept, o_in_stall)
    `LR4X_ASSERT_IMP(a_bypass_paths_quiet, i_clk, i_rst_n,
        r_state == TOP_BYPASS, !lo_stat.busy && !hi_stat.busy)

endmodule

// ===== tb/lr4_audio_crossover_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LR4 audio crossover testbench
// Drives sample words through the crossover, predicts both bands with an
// in-bench fixed-point model of the four biquad sections, and checks each
// result word in order under idle, stall and long hold-off traffic.
// ----------------------------------------------------------------------------
module lr4_audio_crossover_test
    import lr4x_pkg::*;
();

    // Spare indexes of the write channel decode to nothing.
    localparam logic [2:0] CFG_SPARE_A = 3'd5;
    localparam logic [2:0] CFG_SPARE_B = 3'd6;
    localparam logic [2:0] CFG_SPARE_C = 3'd7;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] low;
        logic signed [SAMPLE_BITS-1:0] high;
    } t_band_pair;

    localparam int  HOLD_OFF_CYCLES = 400;
    localparam int  SETTLE_CYCLES   = 4;
    localparam int  DRAIN_CYCLES    = 60;
    localparam int  MAX_REPORTS     = 10;
    localparam real PI_VAL          = 3.14159265358979;
    localparam real SAMPLE_RATE     = 48000.0;
    localparam real BUTTERWORTH_Q   = 0.7071;
    localparam real Q30_SCALE       = 1073741824.0;
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_TOP = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_BOT = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [COEF_BITS-1:0] COEF_TOP = {1'b0, {(COEF_BITS-1){1'b1}}};
    localparam logic [COEF_BITS-1:0] COEF_BOT = {1'b1, {(COEF_BITS-1){1'b0}}};

    // ------------------------------------------------------------------------
    // DUT hookup; every input starts from a known value
    // ------------------------------------------------------------------------
    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_in_valid  = 1'b0;
    logic                          o_in_stall;
    logic signed [SAMPLE_BITS-1:0] i_in_sample = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic signed [SAMPLE_BITS-1:0] o_low_band;
    logic signed [SAMPLE_BITS-1:0] o_high_band;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [2:0]                    i_cfg_index = '0;
    logic [COEF_BITS-1:0]          i_cfg_data  = '0;

    lr4_audio_crossover i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_sample (i_in_sample),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_low_band  (o_low_band),
        .o_high_band (o_high_band),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Band model: register copy, delay lines and the pending result words
    // ------------------------------------------------------------------------
    bit     xover_on;
    longint low_gain;
    longint high_gain;
    longint fb_one;
    longint fb_two;
    longint low_dly[4];
    longint high_dly[4];

    t_band_pair pending_bands[$];

    int fail_count     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // Hold-off request: toggle from the test sequence, served by the receiver.
    bit hold_off_req  = 1'b0;
    bit hold_off_seen = 1'b0;
    int hold_off_left = 0;

    // Add with clamp to the signed 64-bit range instead of wrapping.
    function automatic longint add_sat(input longint a, input longint b);
        longint r;
        r = a + b;
        if ((a < 0) == (b < 0) && (r < 0) != (a < 0)) begin
            r = (a < 0) ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return r;
    endfunction

    // Round half up, then drop n fraction bits.
    function automatic longint round_shift(input longint v, input int n);
        return add_sat(v, 64'sd1 <<< (n - 1)) >>> n;
    endfunction

    function automatic longint clamp_bits(input longint v, input int bits);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi) begin
            return hi;
        end
        if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

    // One transposed direct form II section; updates its two delays in place.
    function automatic longint biquad_step(input longint x, input longint c,
                                           input bit high_pass,
                                           inout longint d0, inout longint d1);
        longint p;
        longint q;
        longint y;
        longint n0;
        longint n1;
        p  = c * x;
        q  = high_pass ? add_sat(-p, -p) : add_sat(p, p);
        y  = clamp_bits(round_shift(add_sat(p, d0 <<< STATE_SHIFT), COEF_FRAC_BITS),
                        SAMPLE_BITS);
        n0 = add_sat(add_sat(q, -(fb_one * y)), d1 <<< STATE_SHIFT);
        n1 = add_sat(p, -(fb_two * y));
        d0 = clamp_bits(round_shift(n0, STATE_SHIFT), STATE_BITS);
        d1 = clamp_bits(round_shift(n1, STATE_SHIFT), STATE_BITS);
        return y;
    endfunction

    // Split one sample into both bands; pass it through and freeze when off.
    function automatic t_band_pair split_bands(input logic signed [SAMPLE_BITS-1:0] s);
        t_band_pair r;
        longint x;
        longint lo;
        longint hi;
        x  = longint'(s);
        lo = x;
        hi = x;
        if (xover_on) begin
            lo = biquad_step(x,  low_gain,  1'b0, low_dly[0],  low_dly[1]);
            lo = biquad_step(lo, low_gain,  1'b0, low_dly[2],  low_dly[3]);
            hi = biquad_step(x,  high_gain, 1'b1, high_dly[0], high_dly[1]);
            hi = biquad_step(hi, high_gain, 1'b1, high_dly[2], high_dly[3]);
        end
        r.low  = lo[SAMPLE_BITS-1:0];
        r.high = hi[SAMPLE_BITS-1:0];
        return r;
    endfunction

    function automatic void apply_reg(input logic [2:0] idx, input logic [COEF_BITS-1:0] v);
        case (idx)
            CFG_ENABLE:    xover_on  = v[0];
            CFG_LOW_GAIN:  low_gain  = longint'($signed(v));
            CFG_HIGH_GAIN: high_gain = longint'($signed(v));
            CFG_FB_ONE:    fb_one    = longint'($signed(v));
            CFG_FB_TWO:    fb_two    = longint'($signed(v));
            default: ;
        endcase
    endfunction

    function automatic logic [COEF_BITS-1:0] to_q30(input real v);
        return COEF_BITS'($rtoi(v * Q30_SCALE));
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: random stall, or a long hold-off counted here on request
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_off_left > 0) begin
            i_out_stall   <= 1'b1;
            hold_off_left <= hold_off_left - 1;
        end else if (hold_off_req != hold_off_seen) begin
            hold_off_seen <= hold_off_req;
            hold_off_left <= HOLD_OFF_CYCLES;
            i_out_stall   <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic report_mismatch(input string what, input longint want, input longint got);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("mismatch %0s: expected %0d, actual %0d", what, want, got);
        end
    endtask

    // Compare every result word taken with the oldest pending one.
    always @(posedge i_clk) begin : check_result
        t_band_pair want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_bands.size() == 0) begin
                report_mismatch("unexpected word, low band", 0, longint'(o_low_band));
            end else begin
                want = pending_bands.pop_front();
                if (want.low !== o_low_band) begin
                    report_mismatch("low band", longint'(want.low), longint'(o_low_band));
                end
                if (want.high !== o_high_band) begin
                    report_mismatch("high band", longint'(want.high), longint'(o_high_band));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender side: one sample word, one register write, idle wait
    // ------------------------------------------------------------------------
    // Enter and leave at a falling edge; valid stays high for a following word.
    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_in_sample <= s;
        do @(posedge i_clk); while (o_in_stall);
        pending_bands.push_back(split_bands(s));
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [COEF_BITS-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg(idx, v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every pending word has come back.
    task automatic settle();
        i_in_valid <= 1'b0;
        wait (pending_bands.size() == 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Butterworth sections for a crossover frequency; shared denominator.
    task automatic program_crossover(input real fc);
        real w0;
        real cw;
        real alpha;
        real a0;
        w0    = 2.0 * PI_VAL * fc / SAMPLE_RATE;
        cw    = $cos(w0);
        alpha = $sin(w0) / (2.0 * BUTTERWORTH_Q);
        a0    = 1.0 + alpha;
        write_reg(CFG_LOW_GAIN,  to_q30((1.0 - cw) / 2.0 / a0));
        write_reg(CFG_HIGH_GAIN, to_q30((1.0 + cw) / 2.0 / a0));
        write_reg(CFG_FB_ONE,    to_q30(-2.0 * cw / a0));
        write_reg(CFG_FB_TWO,    to_q30((1.0 - alpha) / a0));
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
        case ($urandom_range(9))
            0:       return $urandom_range(1) ? SAMPLE_TOP : SAMPLE_BOT;
            1, 2, 3: return SAMPLE_BITS'($signed($urandom_range(2048)) - 1024);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Out of reset the crossover is off: both bands carry the input.
    task automatic test_bypass_after_reset();
        send_sample('0);
        send_sample(SAMPLE_TOP);
        send_sample(SAMPLE_BOT);
        send_sample('1);
        send_sample(SAMPLE_BITS'(24'h555555));
        settle();
    endtask

    // Spare indexes write nothing; enable takes bit 0 only.
    task automatic test_register_decode();
        write_reg(CFG_SPARE_A, $urandom);
        write_reg(CFG_SPARE_B, $urandom);
        write_reg(CFG_SPARE_C, '1);
        write_reg(CFG_ENABLE, {$urandom} & ~COEF_BITS'(1));
        send_sample(SAMPLE_TOP);
        send_sample(SAMPLE_BITS'(24'haaaaaa));
        settle();
    endtask

    // Step and impulse words at both ends of the clamp range.
    task automatic test_directed_bands();
        program_crossover(500.0);
        write_reg(CFG_ENABLE, {$urandom} | COEF_BITS'(1));
        send_sample(SAMPLE_TOP);
        send_sample('0);
        send_sample('0);
        send_sample(SAMPLE_BOT);
        send_sample(SAMPLE_TOP);
        send_sample(SAMPLE_TOP);
        settle();
        program_crossover(60.0);
        send_sample(SAMPLE_BOT);
        send_sample(SAMPLE_BOT);
        send_sample('1);
        settle();
    endtask

    // Unstable coefficients drive state and outputs into saturation.
    task automatic test_extreme_coefs();
        write_reg(CFG_LOW_GAIN,  COEF_TOP);
        write_reg(CFG_HIGH_GAIN, COEF_TOP);
        write_reg(CFG_FB_ONE,    COEF_BOT);
        write_reg(CFG_FB_TWO,    COEF_BOT);
        send_sample(SAMPLE_TOP);
        send_sample(SAMPLE_BOT);
        send_sample(SAMPLE_TOP);
        settle();
        write_reg(CFG_LOW_GAIN,  COEF_BOT);
        write_reg(CFG_HIGH_GAIN, COEF_BOT);
        write_reg(CFG_FB_ONE,    COEF_TOP);
        write_reg(CFG_FB_TWO,    COEF_TOP);
        send_sample(SAMPLE_BOT);
        send_sample(SAMPLE_TOP);
        send_sample(SAMPLE_BOT);
        settle();
    endtask

    // Disabling passes words through and leaves the delays untouched.
    task automatic test_disable_freezes_state();
        program_crossover(250.0);
        send_sample(SAMPLE_BITS'(24'h400000));
        send_sample(SAMPLE_BITS'(24'hc00000));
        settle();
        write_reg(CFG_ENABLE, '0);
        send_sample(SAMPLE_BITS'(24'h123456));
        send_sample(SAMPLE_BOT);
        settle();
        write_reg(CFG_ENABLE, COEF_BITS'(1));
        send_sample('0);
        send_sample('0);
        settle();
    endtask

    // Hold the result channel off while words keep coming, so the block
    // fills up and stalls its input; then release and drain.
    task automatic test_input_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        program_crossover(120.0);
        hold_off_req <= ~hold_off_req;
        repeat (40) send_sample(random_sample());
        settle();
    endtask

    // Random coefficient sets under each idle profile; mostly realistic
    // crossover settings, sometimes raw register noise or bypass.
    task automatic test_random_traffic();
        int send_pcts[4];
        int recv_pcts[4];
        int kind;
        send_pcts = '{0, 57, 0, 28};
        recv_pcts = '{0, 0, 57, 28};
        for (int ph = 0; ph < 8; ph++) begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
            kind = $urandom_range(9);
            if (kind < 7) begin
                program_crossover(real'($urandom_range(60, 499)) +
                                  real'($urandom_range(99)) / 100.0);
            end else begin
                write_reg(CFG_LOW_GAIN,  $urandom);
                write_reg(CFG_HIGH_GAIN, $urandom);
                write_reg(CFG_FB_ONE,    $urandom);
                write_reg(CFG_FB_TWO,    $urandom);
            end
            write_reg(CFG_ENABLE, (kind == 9) ? {$urandom} & ~COEF_BITS'(1)
                                              : {$urandom} | COEF_BITS'(1));
            send_idle_pct  = send_pcts[ph % 4];
            recv_stall_pct = recv_pcts[ph % 4];
            repeat (210) send_sample(random_sample());
            settle();
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        xover_on  = 1'b0;
        low_gain  = 0;
        high_gain = 0;
        fb_one    = 0;
        fb_two    = 0;
        for (int k = 0; k < 4; k++) begin
            low_dly[k]  = 0;
            high_dly[k] = 0;
        end
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_bypass_after_reset();
        test_register_decode();
        test_directed_bands();
        test_extreme_coefs();
        test_disable_freezes_state();
        test_input_backpressure();
        test_random_traffic();

        // Drain, then watch a while longer for stray words.
        i_in_valid <= 1'b0;
        wait (pending_bands.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("lr4_audio_crossover_test passed");
        end else begin
            $display("lr4_audio_crossover_test failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2000000;
        $display("lr4_audio_crossover_test failed");
        $finish;
    end

endmodule
